### rtl/lcdce_pkg.sv
// Package for the character display command encoder.
// Holds the opcode codes, the bus byte constants and the job record that
// passes from the command front end to the byte sequencer. No dependencies.
package lcdce_pkg;

  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_WRITE     = 4'd1,
    OP_CLEAR     = 4'd2,
    OP_HOME      = 4'd3,
    OP_BLINK_ON  = 4'd4,
    OP_BLINK_OFF = 4'd5,
    OP_CURS_ON   = 4'd6,
    OP_CURS_OFF  = 4'd7,
    OP_LINE_FEED = 4'd8,
    OP_BACK      = 4'd9,
    OP_FORWARD   = 4'd10,
    OP_UP        = 4'd11,
    OP_DOWN      = 4'd12,
    OP_DELETE    = 4'd13,
    OP_BACKSPACE = 4'd14,
    OP_COL_MOVE  = 4'd15
  } opcode_e;

  localparam int unsigned JobBytes   = 6;
  localparam int unsigned InitBytes  = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [6:0] DevAddrReset = 7'd62;

  localparam logic [7:0] CtrlCmd    = 8'h80;
  localparam logic [7:0] CtrlData   = 8'h40;
  localparam logic [7:0] SetDdram   = 8'h80;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] InsClear   = 8'h01;
  localparam logic [7:0] InsHome    = 8'h02;
  localparam logic [7:0] CtrlInit   = 8'h0F;

  localparam logic [6:0] LineTwo    = 7'h40;
  localparam logic [6:0] LineOneEnd = 7'h0F;
  localparam logic [6:0] LineTwoEnd = 7'h4F;
  localparam logic [6:0] LineOneOvf = 7'h10;
  localparam logic [6:0] ColMask    = 7'h0F;

  // One queued command, already reduced to the bytes it puts on the bus.
  typedef struct packed {
    logic [6:0]                 addr;
    logic                       is_init;
    logic [3:0]                 count;
    logic [JobBytes-1:0][7:0]   data;
    logic [JobBytes-1:0]        stop;
  } job_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h38;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h39;
      4'd4:    b = 8'h14;
      4'd5:    b = 8'h70;
      4'd6:    b = 8'h54;
      4'd7:    b = 8'h6F;
      4'd8:    b = 8'h0F;
      4'd9:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/lcdce_front.sv
// Command front end: holds the device address, cursor and display-control
// state, and turns each accepted command into a job record.
// Depends on lcdce_pkg.
module lcdce_front import lcdce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  logic [3:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  column_offset_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output job_t        q_job_o
);

  logic [6:0] dev_addr_q, dev_addr_d;
  logic [6:0] cursor_q, cursor_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic       accept;
  job_t       job;

  function automatic logic [6:0] step_back(input logic [6:0] c);
    logic [6:0] r;
    if (c == 7'h00) begin
      r = c;
    end else if (c == LineTwo) begin
      r = LineOneEnd;
    end else begin
      r = c - 7'd1;
    end
    return r;
  endfunction

  assign cmd_ready_o = !q_full_i;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    logic [6:0] c1, c2, c3;
    c1 = '0;
    c2 = '0;
    c3 = '0;
    cursor_d    = cursor_q;
    ctrl_d      = ctrl_q;
    job         = '0;
    job.addr    = dev_addr_q;
    job.data[0] = CtrlCmd;
    case (opcode_e'(opcode_i))
      OP_INIT: begin
        job.is_init = 1'b1;
        job.count   = 4'(InitBytes);
        ctrl_d      = CtrlInit;
        cursor_d    = '0;
      end
      OP_WRITE: begin
        if (cursor_q == LineOneOvf) begin
          job.count   = 4'd4;
          job.data[1] = SetDdram | {1'b0, LineTwo};
          job.data[2] = CtrlData;
          job.data[3] = char_code_i;
          job.stop[3] = 1'b1;
          cursor_d    = LineTwo + 7'd1;
        end else begin
          job.count   = 4'd2;
          job.data[0] = CtrlData;
          job.data[1] = char_code_i;
          job.stop[1] = 1'b1;
          cursor_d    = cursor_q + 7'd1;
        end
      end
      OP_CLEAR: begin
        job.count   = 4'd2;
        job.data[1] = InsClear;
        job.stop[1] = 1'b1;
      end
      OP_HOME: begin
        job.count   = 4'd2;
        job.data[1] = InsHome;
        job.stop[1] = 1'b1;
        cursor_d    = '0;
      end
      OP_BLINK_ON, OP_BLINK_OFF, OP_CURS_ON, OP_CURS_OFF: begin
        case (opcode_e'(opcode_i))
          OP_BLINK_ON:  ctrl_d = ctrl_q | 8'h01;
          OP_BLINK_OFF: ctrl_d = ctrl_q & 8'hFE;
          OP_CURS_ON:   ctrl_d = ctrl_q | 8'h02;
          default:      ctrl_d = ctrl_q & 8'hFD;
        endcase
        job.count   = 4'd2;
        job.data[1] = ctrl_d;
        job.stop[1] = 1'b1;
      end
      OP_LINE_FEED, OP_BACK, OP_FORWARD: begin
        case (opcode_e'(opcode_i))
          OP_LINE_FEED: cursor_d = LineTwo;
          OP_BACK:      cursor_d = step_back(cursor_q);
          default: begin
            if (cursor_q == LineOneEnd) begin
              cursor_d = LineTwo;
            end else if (cursor_q == LineTwoEnd) begin
              cursor_d = cursor_q;
            end else begin
              cursor_d = cursor_q + 7'd1;
            end
          end
        endcase
        job.count   = 4'd2;
        job.data[1] = SetDdram | {1'b0, cursor_d};
        job.stop[1] = 1'b1;
      end
      OP_UP, OP_DOWN: begin
        // A move to the line the cursor is already on produces nothing.
        if (cursor_q[6] == (opcode_i == OP_UP)) begin
          cursor_d    = (opcode_i == OP_UP) ? (cursor_q & ColMask) : (cursor_q | LineTwo);
          job.count   = 4'd2;
          job.data[1] = SetDdram | {1'b0, cursor_d};
          job.stop[1] = 1'b1;
        end
      end
      OP_DELETE: begin
        job.count   = 4'd2;
        job.data[0] = CtrlData;
        job.data[1] = CharSpace;
        job.stop[1] = 1'b1;
        cursor_d    = cursor_q + 7'd1;
      end
      OP_BACKSPACE: begin
        c1          = step_back(cursor_q);
        c2          = c1 + 7'd1;
        c3          = step_back(c2);
        job.count   = 4'd6;
        job.data[1] = SetDdram | {1'b0, c1};
        job.data[2] = CtrlData;
        job.data[3] = CharSpace;
        job.data[4] = CtrlCmd;
        job.data[5] = SetDdram | {1'b0, c3};
        job.stop    = 6'b101010;
        cursor_d    = c3;
      end
      default: begin
        cursor_d    = cursor_q + column_offset_i;
        job.count   = 4'd3;
        job.data[1] = SetDdram | {1'b0, cursor_d};
        job.data[2] = CtrlData;
        job.stop[2] = 1'b1;
      end
    endcase
  end

  assign q_push_o = accept && (job.count != 4'd0);
  assign q_job_o  = job;

  assign dev_addr_d = cfg_we_i ? cfg_wdata_i : dev_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
      cursor_q   <= '0;
      ctrl_q     <= '0;
    end else begin
      dev_addr_q <= dev_addr_d;
      if (accept) begin
        cursor_q <= cursor_d;
        ctrl_q   <= ctrl_d;
      end
    end
  end

endmodule

### rtl/lcdce_queue.sv
// Short job queue between the command front end and the byte sequencer.
// Depends on lcdce_pkg.
module lcdce_queue import lcdce_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  push_job_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output job_t  head_o
);

  job_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]   fill_q, fill_d;
  logic               do_push, do_pop;

  assign full_o  = (fill_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

### rtl/lcdce_back.sv
// Byte sequencer: walks the job at the head of the queue into a registered
// output stage, one byte per cycle unless stalled. Depends on lcdce_pkg.
module lcdce_back import lcdce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] bus_address_o,
  output logic [7:0] data_byte_o,
  output logic       ends_transaction_o,
  output logic       last_o
);

  logic [3:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] addr_q;
  logic [7:0] byte_q, byte_sel;
  logic       stop_q, stop_sel;
  logic       last_q, last_sel;
  logic       advance;

  assign advance = !valid_q || out_ready_i;

  always_comb begin
    byte_sel = '0;
    stop_sel = 1'b0;
    if (job_i.is_init) begin
      byte_sel = init_byte(idx_q);
      stop_sel = (idx_q == 4'(InitBytes - 1));
    end else if (idx_q < 4'(JobBytes)) begin
      byte_sel = job_i.data[idx_q[2:0]];
      stop_sel = job_i.stop[idx_q[2:0]];
    end
    last_sel = (idx_q == job_i.count - 4'd1);
  end

  always_comb begin
    idx_d     = idx_q;
    valid_d   = valid_q;
    job_pop_o = 1'b0;
    if (advance) begin
      valid_d = job_valid_i;
      if (job_valid_i) begin
        if (last_sel) begin
          job_pop_o = 1'b1;
          idx_d     = '0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && job_valid_i) begin
      addr_q <= job_i.addr;
      byte_q <= byte_sel;
      stop_q <= stop_sel;
      last_q <= last_sel;
    end
  end

  assign out_valid_o        = valid_q;
  assign bus_address_o      = addr_q;
  assign data_byte_o        = byte_q;
  assign ends_transaction_o = stop_q;
  assign last_o             = last_q;

endmodule

### rtl/lcd_cursor_command_encoder.sv
// Character display command encoder: one command in, its I2C bus bytes out.
// A command's first byte passes through the job queue and the output register.
// Throughput: one bus byte per cycle from the sequencer unless the output
// stalls; a command has 2 to 10 bytes, and up or down with nothing to do is
// accepted with no output. A four-entry job queue decouples input.
// Reset clears the cursor and display control and loads device address 62.
module lcd_cursor_command_encoder import lcdce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: opcode[3:0], char_code[11:4], column_offset[18:12], zero pad.
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: bus_address[6:0], data_byte[14:7], zero pad.
  output logic [15:0] m_axis_tdata_o,
  // Fields from bit 0: ends_transaction.
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic       q_full, q_push, q_pop, q_valid;
  job_t       push_job, head_job;
  logic [6:0] bus_address;
  logic [7:0] data_byte;
  logic       ends_transaction;

  lcdce_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .cmd_valid_i     (s_axis_tvalid_i),
    .cmd_ready_o     (s_axis_tready_o),
    .opcode_i        (s_axis_tdata_i[3:0]),
    .char_code_i     (s_axis_tdata_i[11:4]),
    .column_offset_i (s_axis_tdata_i[18:12]),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (push_job)
  );

  lcdce_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  lcdce_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i        (q_valid),
    .job_i              (head_job),
    .job_pop_o          (q_pop),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .bus_address_o      (bus_address),
    .data_byte_o        (data_byte),
    .ends_transaction_o (ends_transaction),
    .last_o             (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, data_byte, bus_address};
  assign m_axis_tuser_o = ends_transaction;

endmodule
